// ===== hw/rtl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the WebSocket frame deframer: result codes,
// header length codes and the parser-to-output queue entry.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	// widths of the configuration register and the frame length counter
	localparam int LimitW = 41;
	localparam int LenW   = 64;
	localparam int KeyW   = 32;

	// default depth of the queue between parser and output stage
	localparam int QueueDepthDefault = 2;

	// reset value of the largest accepted payload length
	localparam logic [LimitW-1:0] LIMIT_RESET = 41'h000_0400_0000;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_RSV    = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;

	// one classified result on its way to the output stage
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       fin;
		logic       masked;
		logic       last;
		logic [1:0] error_code;
	} entry_t;

endpackage

// ===== hw/rtl/wsfd_front.sv =====
// ----------------------------------------------------------------------------
// wsfd_front
// Byte parser: walks the frame header, extended length and masking key,
// checks reserved bits and the length limit, and classifies every byte into
// a result entry for the queue. Holds the length limit register.
// ----------------------------------------------------------------------------
module wsfd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   data_byte,
	input  logic                         cfg_write,
	input  logic [wsfd_pkg::LimitW-1:0]  cfg_limit,
	output logic                         push,
	output wsfd_pkg::entry_t             push_entry
);

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_KEY     = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic                          fin_q, fin_d;
	logic [3:0]                    opcode_q, opcode_d;
	logic                          masked_q, masked_d;
	logic [2:0]                    cnt_q, cnt_d;
	logic [wsfd_pkg::LenW-1:0]     rem_q, rem_d;
	logic [wsfd_pkg::KeyW-1:0]     key_q, key_d;
	logic [1:0]                    idx_q, idx_d;
	logic                          err_q, err_d;
	logic [wsfd_pkg::LimitW-1:0]   limit_q;

	logic [wsfd_pkg::LenW-1:0]     len_next;
	logic [wsfd_pkg::LenW-1:0]     rem_dec;
	logic                          len_done;
	logic                          too_large;
	logic [7:0]                    key_byte;
	logic [6:0]                    len7;

	// key byte for the current payload offset, first key byte on top
	assign key_byte = 8'(key_q >> {~idx_q, 3'b000});
	assign rem_dec  = rem_q - wsfd_pkg::LenW'(rem_q != '0);
	assign len7     = data_byte[6:0];

	// next-state and result classification
	always_comb begin
		phase_d  = phase_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		key_d    = key_q;
		idx_d    = idx_q;
		err_d    = err_q;
		push     = 1'b0;
		len_done = 1'b0;
		len_next = '0;
		too_large = 1'b0;
		push_entry = '0;

		if (accept && !err_q) begin
			case (phase_q)
				PH_HDR0: begin
					fin_d    = data_byte[7];
					opcode_d = data_byte[3:0];
					masked_d = 1'b0;
					if (data_byte[6:4] != 3'b000) begin
						err_d                 = 1'b1;
						push                  = 1'b1;
						push_entry.kind       = wsfd_pkg::KIND_ERROR;
						push_entry.last       = 1'b1;
						push_entry.error_code = wsfd_pkg::ERR_RSV;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					masked_d = data_byte[7];
					key_d    = '0;
					idx_d    = '0;
					rem_d    = '0;
					if (len7 == wsfd_pkg::LEN_CODE_16) begin
						cnt_d   = 3'd1;
						phase_d = PH_EXTLEN;
					end else if (len7 == wsfd_pkg::LEN_CODE_64) begin
						cnt_d   = 3'd7;
						phase_d = PH_EXTLEN;
					end else begin
						len_next = {{(wsfd_pkg::LenW-7){1'b0}}, len7};
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					// big-endian length, one byte a transfer
					len_next = {rem_q[wsfd_pkg::LenW-9:0], data_byte};
					rem_d    = len_next;
					if (cnt_q != 3'd0) begin
						cnt_d = cnt_q - 3'd1;
					end else begin
						len_done = 1'b1;
					end
				end
				PH_KEY: begin
					key_d = {key_q[wsfd_pkg::KeyW-9:0], data_byte};
					if (cnt_q != 3'd0) begin
						cnt_d = cnt_q - 3'd1;
					end else if (rem_q == '0) begin
						phase_d         = PH_HDR0;
						push            = 1'b1;
						push_entry.kind = wsfd_pkg::KIND_EMPTY;
						push_entry.last = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					idx_d           = idx_q + 2'd1;
					rem_d           = rem_dec;
					push            = 1'b1;
					push_entry.kind = wsfd_pkg::KIND_PAYLOAD;
					push_entry.data = data_byte;
					push_entry.key  = key_byte;
					push_entry.last = (rem_dec == '0);
					if (rem_dec == '0) begin
						phase_d = PH_HDR0;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// length complete: limit check, then key, payload or empty frame
			if (len_done) begin
				rem_d     = len_next;
				too_large = len_next >
					{{(wsfd_pkg::LenW-wsfd_pkg::LimitW){1'b0}}, limit_q};
				if (too_large) begin
					err_d                 = 1'b1;
					push                  = 1'b1;
					push_entry.kind       = wsfd_pkg::KIND_ERROR;
					push_entry.last       = 1'b1;
					push_entry.error_code = wsfd_pkg::ERR_LENGTH;
				end else if (masked_d) begin
					cnt_d   = 3'd3;
					phase_d = PH_KEY;
				end else if (len_next == '0) begin
					phase_d         = PH_HDR0;
					push            = 1'b1;
					push_entry.kind = wsfd_pkg::KIND_EMPTY;
					push_entry.last = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end

		// frame attributes as updated by this byte
		push_entry.opcode = opcode_d;
		push_entry.fin    = fin_d;
		push_entry.masked = masked_d;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			cnt_q    <= '0;
			rem_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			err_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
			err_q    <= err_d;
		end
	end

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= wsfd_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_limit;
		end
	end

	// error state is sticky until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error state cleared without reset");

	// nothing is emitted once an error has been reported
	a_no_push_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !push)
		else $error("result emitted after error");

	// an error result always latches the error state
	a_err_result_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.kind == wsfd_pkg::KIND_ERROR) |=> err_q)
		else $error("error result without latched error");

endmodule

// ===== hw/rtl/wsfd_queue.sv =====
// ----------------------------------------------------------------------------
// wsfd_queue
// Short FIFO between the parser and the output stage, so that a stalled
// output does not stop the parser until the queue fills.
// ----------------------------------------------------------------------------
module wsfd_queue #(
	parameter int Depth = wsfd_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsfd_pkg::entry_t  push_entry,
	input  logic              pop,
	output wsfd_pkg::entry_t  pop_entry,
	output logic              full,
	output logic              empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	wsfd_pkg::entry_t  slot_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(Depth));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// no write into a full queue, no read from an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overflow or underflow");

endmodule

// ===== hw/rtl/wsfd_back.sv =====
// ----------------------------------------------------------------------------
// wsfd_back
// Output stage: takes queued results, applies the mask key to payload bytes
// and holds each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module wsfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  wsfd_pkg::entry_t  pop_entry,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [1:0]        kind,
	output logic [7:0]        payload_byte,
	output logic [3:0]        opcode,
	output logic              fin,
	output logic              was_masked,
	output logic              frame_last,
	output logic [1:0]        error_code
);

	logic              out_valid_q;
	wsfd_pkg::entry_t  out_q;
	logic [7:0]        byte_q;

	// load the output register when it is free or being taken
	assign pop = !empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, unmasked on the way in
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q  <= pop_entry;
			byte_q <= pop_entry.data ^ pop_entry.key;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign payload_byte = byte_q;
	assign opcode       = out_q.opcode;
	assign fin          = out_q.fin;
	assign was_masked   = out_q.masked;
	assign frame_last   = out_q.last;
	assign error_code   = out_q.error_code;

endmodule

// ===== hw/rtl/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Per-byte WebSocket frame parser with payload unmasking.
// Path: a result is written into the queue at its byte transfer and moves on
//   into the output register once that register is free or being taken.
// Throughput: one byte per cycle while the queue has room (in_stall low).
// Reset: asynchronous, clears parser state and queue; limit = 64 MiB.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top #(
	parameter int QueueDepth = wsfd_pkg::QueueDepthDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [7:0]                  payload_byte,
	output logic [3:0]                  opcode,
	output logic                        fin,
	output logic                        was_masked,
	output logic                        frame_last,
	output logic [1:0]                  error_code,
	// limit register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wsfd_pkg::LimitW-1:0] max_payload_length
);

	logic              accept;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	wsfd_pkg::entry_t  push_entry;
	wsfd_pkg::entry_t  pop_entry;

	// input transfer whenever the queue has room
	assign in_stall  = full;
	assign accept    = in_valid && !full;
	assign cfg_ready = 1'b1;

	wsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.cfg_write  (cfg_valid),
		.cfg_limit  (max_payload_length),
		.push       (push),
		.push_entry (push_entry)
	);

	wsfd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (full),
		.empty      (empty)
	);

	wsfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.payload_byte (payload_byte),
		.opcode       (opcode),
		.fin          (fin),
		.was_masked   (was_masked),
		.frame_last   (frame_last),
		.error_code   (error_code)
	);

endmodule

// ===== tb/tb_websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_top
// Self-checking bench for the WebSocket frame deframer. Frames are built byte
// by byte and pushed through the input channel. A byte-level predictor of the
// parser produces the expected results, and each output transfer is checked
// against them in order. Runs under several length limits and idle patterns,
// holds the output off for a long stretch, and ends with the sticky error.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_top;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_BYTES   = 550;
	localparam logic [wsfd_pkg::LimitW-1:0] LIMIT_MAX = 41'h100_0000_0000;

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_EXTLEN, PH_KEY, PH_PAYLOAD
	} parse_phase_t;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
	typedef enum int {FAULT_RSV, FAULT_LEN, FAULT_LEN64} fault_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pbyte;
		logic [3:0] opc;
		logic       fin;
		logic       masked;
		logic       last;
		logic [1:0] ecode;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [wsfd_pkg::LimitW-1:0] max_payload_length = '0;
	logic in_stall, out_valid, cfg_ready;
	logic [1:0] kind, error_code;
	logic [7:0] payload_byte;
	logic [3:0] opcode;
	logic fin, was_masked, frame_last;

	// predictor state
	parse_phase_t phase_q = PH_HDR0;
	logic fin_q = 1'b0;
	logic [3:0] opc_q = 4'h0;
	logic masked_q = 1'b0;
	logic [2:0] cnt_q = 3'd0;
	logic [63:0] remain_q = 64'd0;
	logic [31:0] key_q = 32'd0;
	logic [1:0] kidx_q = 2'd0;
	logic dead_q = 1'b0;
	logic [wsfd_pkg::LimitW-1:0] limit_q = wsfd_pkg::LIMIT_RESET;

	frame_result_t pending_frame_results[$];

	int send_idle = 0;
	int recv_idle = 0;
	int mismatch_count = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int limit_writes = 0;
	int cycle_count = 0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	fault_t fault_kind = FAULT_RSV;

	websocket_frame_deframer_top i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.data_byte          (data_byte),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.kind               (kind),
		.payload_byte       (payload_byte),
		.opcode             (opcode),
		.fin                (fin),
		.was_masked         (was_masked),
		.frame_last         (frame_last),
		.error_code         (error_code),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.max_payload_length (max_payload_length)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_frame_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result with the current frame's header fields
	function automatic frame_result_t make_result(input logic [1:0] k,
			input logic [7:0] pb, input logic lst, input logic [1:0] ec);
		frame_result_t r;
		r.kind   = k;
		r.pbyte  = pb;
		r.opc    = opc_q;
		r.fin    = fin_q;
		r.masked = masked_q;
		r.last   = lst;
		r.ecode  = ec;
		return r;
	endfunction

	// length known: limit check, then key, payload or empty-frame result
	function automatic bit length_complete(output frame_result_t r);
		r = '0;
		if (remain_q > 64'(limit_q)) begin
			dead_q = 1'b1;
			r = make_result(wsfd_pkg::KIND_ERROR, 8'h00, 1'b1, wsfd_pkg::ERR_LENGTH);
			return 1'b1;
		end
		if (masked_q) begin
			cnt_q = 3'd3;
			phase_q = PH_KEY;
			return 1'b0;
		end
		if (remain_q == 64'd0) begin
			phase_q = PH_HDR0;
			r = make_result(wsfd_pkg::KIND_EMPTY, 8'h00, 1'b1, wsfd_pkg::ERR_NONE);
			return 1'b1;
		end
		phase_q = PH_PAYLOAD;
		return 1'b0;
	endfunction

	// one received byte through the parser; returns 1 when it gives a result
	function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
		logic [7:0] kb;
		r = '0;
		if (dead_q)
			return 1'b0;
		case (phase_q)
			PH_HDR0: begin
				fin_q = b[7];
				opc_q = b[3:0];
				masked_q = 1'b0;
				if (b[6:4] != 3'b000) begin
					dead_q = 1'b1;
					r = make_result(wsfd_pkg::KIND_ERROR, 8'h00, 1'b1,
						wsfd_pkg::ERR_RSV);
					return 1'b1;
				end
				phase_q = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				masked_q = b[7];
				key_q = 32'd0;
				kidx_q = 2'd0;
				remain_q = 64'd0;
				if (b[6:0] == wsfd_pkg::LEN_CODE_16) begin
					cnt_q = 3'd1;
					phase_q = PH_EXTLEN;
					return 1'b0;
				end
				if (b[6:0] == wsfd_pkg::LEN_CODE_64) begin
					cnt_q = 3'd7;
					phase_q = PH_EXTLEN;
					return 1'b0;
				end
				remain_q = 64'(b[6:0]);
				return length_complete(r);
			end
			PH_EXTLEN: begin
				remain_q = {remain_q[55:0], b};
				if (cnt_q != 3'd0) begin
					cnt_q = cnt_q - 3'd1;
					return 1'b0;
				end
				return length_complete(r);
			end
			PH_KEY: begin
				key_q = {key_q[23:0], b};
				if (cnt_q != 3'd0) begin
					cnt_q = cnt_q - 3'd1;
					return 1'b0;
				end
				if (remain_q == 64'd0) begin
					phase_q = PH_HDR0;
					r = make_result(wsfd_pkg::KIND_EMPTY, 8'h00, 1'b1,
						wsfd_pkg::ERR_NONE);
					return 1'b1;
				end
				phase_q = PH_PAYLOAD;
				return 1'b0;
			end
			PH_PAYLOAD: begin
				kb = key_q[8*(3-kidx_q) +: 8];
				kidx_q = kidx_q + 2'd1;
				if (remain_q != 64'd0)
					remain_q = remain_q - 64'd1;
				if (remain_q == 64'd0) begin
					phase_q = PH_HDR0;
					r = make_result(wsfd_pkg::KIND_PAYLOAD, b ^ kb, 1'b1,
						wsfd_pkg::ERR_NONE);
				end else begin
					r = make_result(wsfd_pkg::KIND_PAYLOAD, b ^ kb, 1'b0,
						wsfd_pkg::ERR_NONE);
				end
				return 1'b1;
			end
			default: begin
				phase_q = PH_HDR0;
				return 1'b0;
			end
		endcase
	endfunction

	// output side: random stall, or a long hold when the test asks for one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic report_mismatch(input string what, input frame_result_t exp_r,
			input frame_result_t got_r);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch (%s) cycle %0d:", what, cycle_count);
			$display("  exp kind=%0d byte=%02h op=%0h fin=%0d mask=%0d last=%0d err=%0d",
				exp_r.kind, exp_r.pbyte, exp_r.opc, exp_r.fin, exp_r.masked,
				exp_r.last, exp_r.ecode);
			$display("  got kind=%0d byte=%02h op=%0h fin=%0d mask=%0d last=%0d err=%0d",
				got_r.kind, got_r.pbyte, got_r.opc, got_r.fin, got_r.masked,
				got_r.last, got_r.ecode);
		end
	endtask

	// result checker: every output transfer against the oldest expectation
	always @(posedge clk) begin
		frame_result_t got_r;
		frame_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got_r = '{kind, payload_byte, opcode, fin, was_masked, frame_last, error_code};
			results_seen++;
			if (pending_frame_results.size() == 0) begin
				report_mismatch("no result expected", '0, got_r);
			end else begin
				exp_r = pending_frame_results.pop_front();
				if (got_r !== exp_r)
					report_mismatch("field", exp_r, got_r);
			end
		end
	end

	task automatic set_idle(input int s, input int r);
		send_idle = s;
		recv_idle = r;
	endtask

	// one byte transfer; valid stays high afterwards until the next call
	task automatic send_byte(input logic [7:0] b);
		frame_result_t r;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		bytes_sent++;
		if (deframe_byte(b, r))
			pending_frame_results.push_back(r);
	endtask

	// sender pause until every expected result has come, plus pipeline slack
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_frame_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [wsfd_pkg::LimitW-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		max_payload_length <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		limit_q = v;
		limit_writes++;
	endtask

	// header, extended length, key and payload of one frame
	task automatic send_frame(input logic f, input logic [3:0] op, input logic m,
			input len_form_t form, input logic [63:0] len, input logic [31:0] key,
			input fill_t fill);
		logic [7:0] pb;
		frames_sent++;
		send_byte({f, 3'b000, op});
		case (form)
			LEN_SHORT: send_byte({m, len[6:0]});
			LEN_EXT16: begin
				send_byte({m, wsfd_pkg::LEN_CODE_16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({m, wsfd_pkg::LEN_CODE_64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8*i +: 8]);
			end
		endcase
		// rejected length: the rest of the frame would only be dropped
		if (dead_q)
			return;
		if (m)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8*i +: 8]);
		for (longint unsigned n = 0; n < len; n++) begin
			case (fill)
				FILL_ZERO: pb = 8'h00;
				FILL_ONES: pb = 8'hFF;
				default:   pb = 8'($urandom);
			endcase
			send_byte(pb);
		end
	endtask

	// field extremes, both opcodes ends, every length form, empty frames
	task automatic test_directed_frames();
		send_frame(1'b1, 4'h1, 1'b1, LEN_SHORT, 64'd0, 32'h1234_5678, FILL_RANDOM);
		send_frame(1'b1, 4'hF, 1'b1, LEN_EXT16, 64'd2, 32'hFFFF_FFFF, FILL_ONES);
		send_frame(1'b0, 4'h0, 1'b0, LEN_EXT64, 64'd0, 32'h0, FILL_ZERO);
		send_frame(1'b0, 4'h0, 1'b0, LEN_SHORT, 64'd1, 32'h0, FILL_ONES);
		send_frame(1'b1, 4'h9, 1'b0, LEN_SHORT, 64'd1, 32'h0, FILL_ZERO);
		wait_drained();
	endtask

	// limit of zero still lets empty frames through
	task automatic test_zero_limit();
		write_limit('0);
		send_frame(1'b1, 4'h8, 1'b0, LEN_SHORT, 64'd0, 32'h0, FILL_RANDOM);
		send_frame(1'b0, 4'h2, 1'b1, LEN_SHORT, 64'd0, $urandom, FILL_RANDOM);
		send_frame(1'b1, 4'hA, 1'b1, LEN_EXT16, 64'd0, $urandom, FILL_RANDOM);
		send_frame(1'b0, 4'h9, 1'b0, LEN_EXT64, 64'd0, 32'h0, FILL_RANDOM);
		wait_drained();
	endtask

	// length exactly at the limit is accepted
	task automatic test_limit_boundary();
		logic [wsfd_pkg::LimitW-1:0] lim;
		lim = wsfd_pkg::LimitW'($urandom_range(20, 1));
		write_limit(lim);
		send_frame(1'b1, 4'h2, 1'b1, LEN_SHORT, 64'(lim), $urandom, FILL_RANDOM);
		send_frame(1'b0, 4'h1, 1'b0, LEN_EXT64, 64'(lim) - 64'd1, 32'h0, FILL_RANDOM);
		wait_drained();
	endtask

	// output held off while the sender keeps offering bytes
	task automatic test_receiver_hold();
		write_limit(LIMIT_MAX);
		hold_toggle <= ~hold_toggle;
		send_frame(1'b1, 4'h2, 1'b1, LEN_EXT16, 64'd40, $urandom, FILL_RANDOM);
		wait_drained();
	endtask

	task automatic pick_random_limit();
		case ($urandom_range(3))
			0: write_limit(LIMIT_MAX);
			1: write_limit(wsfd_pkg::LIMIT_RESET);
			2: write_limit(wsfd_pkg::LimitW'($urandom_range(300, 40)));
			default: write_limit({1'b0, 8'($urandom), 32'($urandom)});
		endcase
	endtask

	task automatic send_random_frame();
		int unsigned sel;
		logic [63:0] len;
		len_form_t form;
		sel = $urandom_range(99);
		if (sel < 70)
			len = 64'($urandom_range(8));
		else if (sel < 90)
			len = 64'($urandom_range(40, 9));
		else if (sel < 98)
			len = 64'($urandom_range(125, 41));
		else
			len = 64'($urandom_range(300, 126));
		if (len > 64'(limit_q))
			len = 64'(limit_q);
		sel = $urandom_range(9);
		if (len > 64'd125 || sel == 0)
			form = LEN_EXT16;
		else if (sel == 1)
			form = LEN_EXT64;
		else
			form = LEN_SHORT;
		send_frame(1'($urandom), 4'($urandom), 1'($urandom), form, len, $urandom,
			FILL_RANDOM);
	endtask

	// well-formed frames with random content, two limit settings per call
	task automatic test_random_traffic(input int target);
		int start;
		for (int half = 0; half < 2; half++) begin
			pick_random_limit();
			start = bytes_sent;
			while (bytes_sent - start < target / 2)
				send_random_frame();
		end
		wait_drained();
	endtask

	// one error per run: it latches, later bytes and a limit write change nothing
	task automatic test_error_latch();
		logic [wsfd_pkg::LimitW-1:0] lim;
		wait_drained();
		fault_kind = fault_t'($urandom_range(2));
		case (fault_kind)
			FAULT_RSV: send_byte({1'($urandom), 3'($urandom_range(7, 1)), 4'($urandom)});
			FAULT_LEN: begin
				lim = wsfd_pkg::LimitW'($urandom_range(200));
				write_limit(lim);
				send_frame(1'($urandom), 4'($urandom), 1'($urandom),
					(lim < 125) ? LEN_SHORT : LEN_EXT16, 64'(lim) + 64'd1,
					$urandom, FILL_RANDOM);
			end
			default: begin
				write_limit(LIMIT_MAX);
				send_frame(1'($urandom), 4'($urandom), 1'($urandom), LEN_EXT64,
					{1'b1, 31'($urandom), 32'($urandom)}, $urandom, FILL_RANDOM);
			end
		endcase
		repeat (20) send_byte(8'($urandom));
		write_limit(LIMIT_MAX);
		send_frame(1'b1, 4'h1, 1'b0, LEN_SHORT, 64'd3, 32'h0, FILL_RANDOM);
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(36, 83);
		test_directed_frames();
		test_zero_limit();
		test_limit_boundary();
		test_receiver_hold();
		test_random_traffic(RANDOM_BYTES);
		set_idle(83, 36);
		test_random_traffic(RANDOM_BYTES);
		set_idle(0, 0);
		test_random_traffic(RANDOM_BYTES);
		test_error_latch();

		repeat (20) @(posedge clk);
		$display("Ran %0d bytes in %0d frames, %0d results checked,",
			bytes_sent, frames_sent, results_seen);
		$display("%0d limit writes (0 and 2^40 included).", limit_writes);
		$display("Closing error case: %s; %0d mismatches.", fault_kind.name(), mismatch_count);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_front.sv
hw/rtl/wsfd_queue.sv
hw/rtl/wsfd_back.sv
hw/rtl/websocket_frame_deframer_top.sv
tb/tb_websocket_frame_deframer_top.sv
